FILE: rtl/cle_pkg.sv
// ----------------------------------------------------------------------------
// cle_pkg
// Shared constants and types of the console line editor.
// ----------------------------------------------------------------------------
package cle_pkg;

	localparam int LINE_SIZE_DEF = 128;
	localparam int CW            = 8;   // count and byte width

	// result action codes
	localparam logic [2:0] ACT_NONE  = 3'd0;
	localparam logic [2:0] ACT_ECHO  = 3'd1;
	localparam logic [2:0] ACT_TAB   = 3'd2;
	localparam logic [2:0] ACT_ERASE = 3'd3;
	localparam logic [2:0] ACT_DONE  = 3'd4;
	localparam logic [2:0] ACT_INTR  = 3'd5;
	localparam logic [2:0] ACT_BELL  = 3'd6;
	localparam logic [2:0] ACT_READ  = 3'd7;

	// command codes
	localparam logic CMD_KEY  = 1'b0;
	localparam logic CMD_READ = 1'b1;

	// key codes
	localparam logic [7:0] KEY_NUL   = 8'h00;
	localparam logic [7:0] KEY_CTRLC = 8'h03;
	localparam logic [7:0] KEY_BS    = 8'h08;
	localparam logic [7:0] KEY_TAB   = 8'h09;
	localparam logic [7:0] KEY_LF    = 8'h0A;
	localparam logic [7:0] KEY_CR    = 8'h0D;
	localparam logic [7:0] KEY_CTRLU = 8'h15;
	localparam logic [7:0] KEY_CTRLW = 8'h17;
	localparam logic [7:0] KEY_SPACE = 8'h20;
	localparam logic [7:0] KEY_DEL   = 8'h7F;

	typedef struct packed {
		logic          we;
		logic [CW-1:0] waddr;
		logic [CW-1:0] wdata;
		logic [CW-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic          valid;
		logic [2:0]    action;
		logic [CW-1:0] echo_char;
		logic [CW-1:0] erase_count;
		logic [CW-1:0] line_length;
		logic [CW-1:0] read_data;
	} res_t;

endpackage

FILE: rtl/console_line_editor_top.sv
// ----------------------------------------------------------------------------
// console_line_editor_top
// Terminal line editor: edits a line store from key bytes, answers reads.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  request  | start, busy          | command, key_byte, read_index
//  result   | done (1-cycle pulse) | action, echo_char, erase_count,
//           |                      | line_length, read_data
//
//  Plain keys, NUL, Enter, ^C, ^U, BS/DEL: execute state, then finish state.
//  Reads add a state for the registered store read. TAB writes the store
//  once per cycle for the four entries. ^W on an empty line runs like a
//  plain key, else through read and check states per erased character until
//  the line empties or stops at a space; each entry check is one store read.
//  Next request is taken in the cycle done is high. Reset clears count and
//  line state; the store holds no reset value. Results cannot be stalled.
// ----------------------------------------------------------------------------
module console_line_editor_top #(
	parameter int LINE_SIZE = cle_pkg::LINE_SIZE_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic                   command,
	input  logic [cle_pkg::CW-1:0] key_byte,
	input  logic [cle_pkg::CW-1:0] read_index,
	output logic                   done,
	output logic [2:0]             action,
	output logic [cle_pkg::CW-1:0] echo_char,
	output logic [cle_pkg::CW-1:0] erase_count,
	output logic [cle_pkg::CW-1:0] line_length,
	output logic [cle_pkg::CW-1:0] read_data
);

	cle_pkg::mem_req_t      mem_req;
	logic [cle_pkg::CW-1:0] mem_rdata;
	cle_pkg::res_t          res;

	cle_store #(.LINE_SIZE(LINE_SIZE)) u_store (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	cle_ctrl #(.LINE_SIZE(LINE_SIZE)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.command    (command),
		.key_byte   (key_byte),
		.read_index (read_index),
		.mem_rdata  (mem_rdata),
		.mem_req    (mem_req),
		.res        (res),
		.busy       (busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= res.valid;
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			action      <= res.action;
			echo_char   <= res.echo_char;
			erase_count <= res.erase_count;
			line_length <= res.line_length;
			read_data   <= res.read_data;
		end
	end

endmodule

FILE: rtl/cle_store.sv
// ----------------------------------------------------------------------------
// cle_store
// Line store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cle_store #(
	parameter int LINE_SIZE = cle_pkg::LINE_SIZE_DEF
) (
	input  logic                   clk,
	input  cle_pkg::mem_req_t      req,
	output logic [cle_pkg::CW-1:0] rdata
);

	localparam int DEPTH = LINE_SIZE + 1;
	localparam int AW    = $clog2(DEPTH);

	logic [cle_pkg::CW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (req.we)
			mem[req.waddr[AW-1:0]] <= req.wdata;
		rdata <= mem[req.raddr[AW-1:0]];
	end

endmodule

FILE: rtl/cle_ctrl.sv
// ----------------------------------------------------------------------------
// cle_ctrl
// Key decode sequencer with a shared count step; walks the store for ^W
// and writes the tab expansion one entry per cycle.
// ----------------------------------------------------------------------------
module cle_ctrl #(
	parameter int LINE_SIZE = cle_pkg::LINE_SIZE_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   command,
	input  logic [cle_pkg::CW-1:0] key_byte,
	input  logic [cle_pkg::CW-1:0] read_index,
	input  logic [cle_pkg::CW-1:0] mem_rdata,
	output cle_pkg::mem_req_t      mem_req,
	output cle_pkg::res_t          res,
	output logic                   busy
);

	localparam int CW = cle_pkg::CW;
	localparam logic [CW-1:0] LIMIT = CW'(LINE_SIZE - 2);
	localparam logic [CW-1:0] ONE   = CW'(1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXEC = 3'd1;
	localparam logic [2:0] ST_RDAT = 3'd2;
	localparam logic [2:0] ST_TABW = 3'd3;
	localparam logic [2:0] ST_WRD  = 3'd4;
	localparam logic [2:0] ST_WCHK = 3'd5;
	localparam logic [2:0] ST_FIN  = 3'd6;

	logic [2:0]    state_q;
	logic          cmd_q;
	logic [CW-1:0] key_q, idx_q;
	logic [CW-1:0] cnt_q, ers_q, rdata_q;
	logic [2:0]    act_q;
	logic [1:0]    rem_q;
	logic          closed_q;

	// shared count unit: +1 or -1
	logic          dec;
	logic [CW-1:0] cnt_step;
	assign cnt_step = dec ? (cnt_q - ONE) : (cnt_q + ONE);

	always_comb begin
		dec = (state_q == ST_EXEC) || (state_q == ST_WRD) || (state_q == ST_WCHK);
	end

	always_comb begin
		mem_req       = '0;
		mem_req.raddr = (state_q == ST_WRD) ? cnt_step : idx_q;
		mem_req.waddr = cnt_q;
		if (state_q == ST_TABW) begin
			mem_req.we    = 1'b1;
			mem_req.wdata = (rem_q != 2'd0) ? cle_pkg::KEY_SPACE : key_q;
		end else begin
			mem_req.wdata = key_q;
			mem_req.we    = (state_q == ST_EXEC) && (cmd_q == cle_pkg::CMD_KEY) &&
			                (key_q != cle_pkg::KEY_TAB) && (cnt_q < LIMIT);
			case (key_q)
				cle_pkg::KEY_CR, cle_pkg::KEY_LF, cle_pkg::KEY_NUL, cle_pkg::KEY_CTRLC,
				cle_pkg::KEY_CTRLU, cle_pkg::KEY_CTRLW, cle_pkg::KEY_BS,
				cle_pkg::KEY_DEL: mem_req.we = 1'b0;
				default: ;
			endcase
		end
	end

	always_comb begin
		res             = '0;
		res.valid       = (state_q == ST_FIN);
		res.action      = act_q;
		res.line_length = cnt_q;
		res.echo_char   = (act_q == cle_pkg::ACT_ECHO)  ? key_q   : '0;
		res.erase_count = (act_q == cle_pkg::ACT_ERASE) ? ers_q   : '0;
		res.read_data   = (act_q == cle_pkg::ACT_READ)  ? rdata_q : '0;
	end

	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			closed_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_EXEC;
						if (command == cle_pkg::CMD_KEY && closed_q) begin
							cnt_q    <= '0;
							closed_q <= 1'b0;
						end
					end
				end
				ST_EXEC: begin
					state_q <= ST_FIN;
					if (cmd_q == cle_pkg::CMD_READ) begin
						state_q <= ST_RDAT;
					end else begin
						case (key_q)
							cle_pkg::KEY_CR, cle_pkg::KEY_LF: closed_q <= 1'b1;
							cle_pkg::KEY_NUL: ;
							cle_pkg::KEY_CTRLC, cle_pkg::KEY_CTRLU: cnt_q <= '0;
							cle_pkg::KEY_CTRLW: begin
								if (cnt_q != '0) begin
									cnt_q   <= cnt_step;
									state_q <= ST_WRD;
								end
							end
							cle_pkg::KEY_BS, cle_pkg::KEY_DEL: begin
								if (cnt_q != '0)
									cnt_q <= cnt_step;
							end
							default: begin
								if (cnt_q < LIMIT) begin
									if (key_q == cle_pkg::KEY_TAB)
										state_q <= ST_TABW;
									else
										cnt_q <= cnt_q + ONE;
								end
							end
						endcase
					end
				end
				ST_RDAT: state_q <= ST_FIN;
				ST_TABW: begin
					cnt_q <= cnt_step;
					if (rem_q == 2'd0)
						state_q <= ST_FIN;
				end
				ST_WRD: begin
					if (cnt_q == '0)
						state_q <= ST_FIN;
					else
						state_q <= ST_WCHK;
				end
				ST_WCHK: begin
					if (mem_rdata != cle_pkg::KEY_SPACE) begin
						cnt_q   <= cnt_step;
						state_q <= ST_WRD;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				cmd_q   <= command;
				key_q   <= key_byte;
				idx_q   <= read_index;
				ers_q   <= '0;
				rdata_q <= '0;
				rem_q   <= 2'd3;
				act_q   <= cle_pkg::ACT_NONE;
			end
			ST_EXEC: begin
				if (cmd_q == cle_pkg::CMD_READ) begin
					act_q <= cle_pkg::ACT_READ;
				end else begin
					case (key_q)
						cle_pkg::KEY_CR, cle_pkg::KEY_LF: act_q <= cle_pkg::ACT_DONE;
						cle_pkg::KEY_NUL: act_q <= cle_pkg::ACT_NONE;
						cle_pkg::KEY_CTRLC: act_q <= cle_pkg::ACT_INTR;
						cle_pkg::KEY_CTRLU: begin
							if (cnt_q != '0) begin
								ers_q <= cnt_q;
								act_q <= cle_pkg::ACT_ERASE;
							end
						end
						cle_pkg::KEY_CTRLW, cle_pkg::KEY_BS, cle_pkg::KEY_DEL: begin
							if (cnt_q != '0) begin
								ers_q <= ONE;
								act_q <= cle_pkg::ACT_ERASE;
							end
						end
						default: begin
							if (cnt_q >= LIMIT)
								act_q <= cle_pkg::ACT_BELL;
							else if (key_q == cle_pkg::KEY_TAB)
								act_q <= cle_pkg::ACT_TAB;
							else
								act_q <= cle_pkg::ACT_ECHO;
						end
					endcase
				end
			end
			ST_RDAT: begin
				if (idx_q < cnt_q)
					rdata_q <= mem_rdata;
			end
			ST_TABW: rem_q <= rem_q - 2'd1;
			ST_WCHK: begin
				if (mem_rdata != cle_pkg::KEY_SPACE)
					ers_q <= ers_q + ONE;
			end
			default: ;
		endcase
	end

endmodule

FILE: rtl/cle_checker.sv
// ----------------------------------------------------------------------------
// cle_checker
// Port-level checks of the console line editor.
// ----------------------------------------------------------------------------
module cle_checker #(
	parameter int LINE_SIZE = cle_pkg::LINE_SIZE_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   start,
	input logic                   busy,
	input logic                   done,
	input logic [2:0]             action,
	input logic [cle_pkg::CW-1:0] echo_char,
	input logic [cle_pkg::CW-1:0] erase_count,
	input logic [cle_pkg::CW-1:0] line_length,
	input logic [cle_pkg::CW-1:0] read_data
);

	localparam logic [cle_pkg::CW-1:0] MAX_LEN = cle_pkg::CW'(LINE_SIZE + 1);

	// an accepted request holds busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("request accepted but not busy");

	// done is a pulse and is never held high
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held for two cycles");

	a_len_max: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> line_length <= MAX_LEN) else $error("line length out of range");

	a_erase_only: assert property (@(posedge clk) disable iff (!arst_n)
		done && action != cle_pkg::ACT_ERASE |-> erase_count == '0)
		else $error("erase count on non-erase result");

	a_side_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (action == cle_pkg::ACT_ECHO || echo_char == '0) &&
		         (action == cle_pkg::ACT_READ || read_data == '0))
		else $error("echo or read data on wrong action");

endmodule

bind console_line_editor_top cle_checker #(.LINE_SIZE(LINE_SIZE)) u_cle_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.action      (action),
	.echo_char   (echo_char),
	.erase_count (erase_count),
	.line_length (line_length),
	.read_data   (read_data)
);

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for console_line_editor_top. A short scripted sequence
// covers empty-line erases, echo, TAB, reads, word erase, Enter, ^U and ^C.
// It is followed by random typing sessions, long lines that hit the length
// limit, and noise bytes. Every request is run through an independent line
// editor model and each done pulse is compared against the oldest expected result.
// ----------------------------------------------------------------------------
module testbench;

	import cle_pkg::*;

	localparam int LINE_SIZE   = LINE_SIZE_DEF;
	localparam int STORE_DEPTH = LINE_SIZE + 1;
	localparam int ITEMS       = 1200;
	localparam int QUIET_TAIL  = 150;   // last requests go back to back
	localparam int SCRIPT_LEN  = 25;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] echo_char;
		logic [7:0] erase_count;
		logic [7:0] line_length;
		logic [7:0] read_data;
	} editor_result_t;

	typedef struct packed {
		logic           cmd;
		logic [7:0]     key;
		logic [7:0]     idx;
		logic           typed;
		editor_result_t want;
	} script_row_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic       command;
	logic [7:0] key_byte;
	logic [7:0] read_index;
	logic       done;
	logic [2:0] action;
	logic [7:0] echo_char;
	logic [7:0] erase_count;
	logic [7:0] line_length;
	logic [7:0] read_data;

	// model state
	logic [7:0] line_copy [STORE_DEPTH];
	int         line_len;
	logic       line_ended;

	editor_result_t pending_results [$];
	script_row_t    script [SCRIPT_LEN];
	int             mismatches;
	int             sent;
	int             gap_pct;

	console_line_editor_top #(.LINE_SIZE(LINE_SIZE)) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.command    (command),
		.key_byte   (key_byte),
		.read_index (read_index),
		.done       (done),
		.action     (action),
		.echo_char  (echo_char),
		.erase_count(erase_count),
		.line_length(line_length),
		.read_data  (read_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic editor_result_t edit_line(input logic cmd, input logic [7:0] key,
			input logic [7:0] idx);
		editor_result_t r;
		r = '0;
		r.action = ACT_NONE;
		if (cmd == CMD_READ) begin
			r.action = ACT_READ;
			if (int'(idx) < line_len)
				r.read_data = line_copy[idx];
		end else begin
			// first key after Enter opens a fresh line
			if (line_ended) begin
				line_len = 0;
				line_ended = 1'b0;
			end
			case (key)
				KEY_CR, KEY_LF: begin
					r.action = ACT_DONE;
					line_ended = 1'b1;
				end
				KEY_NUL: ;
				KEY_CTRLC: begin
					line_len = 0;
					r.action = ACT_INTR;
				end
				KEY_CTRLU: if (line_len > 0) begin
					r.erase_count = 8'(line_len);
					line_len = 0;
					r.action = ACT_ERASE;
				end
				KEY_CTRLW: if (line_len > 0) begin
					line_len--;
					r.erase_count = 8'd1;
					while (line_len > 0 && line_copy[line_len-1] != KEY_SPACE) begin
						line_len--;
						r.erase_count++;
					end
					r.action = ACT_ERASE;
				end
				KEY_BS, KEY_DEL: if (line_len > 0) begin
					line_len--;
					r.erase_count = 8'd1;
					r.action = ACT_ERASE;
				end
				default: if (line_len < LINE_SIZE - 2) begin
					if (key == KEY_TAB) begin
						for (int k = 0; k < 3; k++)
							line_copy[line_len+k] = KEY_SPACE;
						line_len += 3;
						r.action = ACT_TAB;
					end else begin
						r.action = ACT_ECHO;
						r.echo_char = key;
					end
					line_copy[line_len] = key;
					line_len++;
				end else begin
					r.action = ACT_BELL;
				end
			endcase
		end
		r.line_length = 8'(line_len);
		return r;
	endfunction

	// kind 0: ordinary typing, 1: long line, 2: noise
	function automatic logic [7:0] pick_key(input int kind);
		int roll;
		roll = $urandom_range(99);
		if (kind == 2)
			return 8'($urandom_range(255));
		if (kind == 1) begin
			if (roll < 85) return 8'($urandom_range(8'h7E, 8'h21));
			if (roll < 93) return KEY_SPACE;
			return KEY_TAB;
		end
		if (roll < 55) return 8'($urandom_range(8'h7E, 8'h21));
		if (roll < 67) return KEY_SPACE;
		if (roll < 72) return KEY_TAB;
		if (roll < 76) return KEY_BS;
		if (roll < 80) return KEY_DEL;
		if (roll < 85) return KEY_CTRLW;
		if (roll < 87) return KEY_CTRLU;
		if (roll < 89) return KEY_CTRLC;
		if (roll < 91) return KEY_NUL;
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [7:0] pick_index();
		if (line_len > 0 && $urandom_range(99) < 80)
			return 8'($urandom_range(line_len - 1));
		return 8'($urandom_range(STORE_DEPTH - 1));
	endfunction

	task automatic issue(input logic cmd, input logic [7:0] key, input logic [7:0] idx,
			input logic typed, input editor_result_t want);
		editor_result_t predicted;
		if (sent < ITEMS - QUIET_TAIL && $urandom_range(99) < gap_pct) begin
			@(negedge clk);
			start <= 1'b0;
			key_byte <= 8'($urandom);
			read_index <= 8'($urandom);
			repeat ($urandom_range(13)) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		command <= cmd;
		key_byte <= key;
		read_index <= idx;
		do @(posedge clk); while (busy);
		predicted = edit_line(cmd, key, idx);
		pending_results.push_back(typed ? want : predicted);
		sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] seen);
		if (seen !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, seen);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		editor_result_t oldest;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, action %0d", $time, action);
				mismatches++;
			end else begin
				oldest = pending_results.pop_front();
				check_field("action", 8'(oldest.action), 8'(action));
				check_field("echo_char", oldest.echo_char, echo_char);
				check_field("erase_count", oldest.erase_count, erase_count);
				check_field("line_length", oldest.line_length, line_length);
				check_field("read_data", oldest.read_data, read_data);
			end
		end
	end

	initial begin
		#10_000_000;
		$display("testbench: errors");
		$finish;
	end

	initial begin
		int kind;
		int nkeys;
		arst_n = 1'b0;
		start = 1'b0;
		command = CMD_KEY;
		key_byte = '0;
		read_index = '0;
		mismatches = 0;
		sent = 0;
		gap_pct = 0;
		line_len = 0;
		line_ended = 1'b0;

		script = '{
			'{CMD_READ, 8'h00, 8'd0, 1'b1, '{ACT_READ, 8'h00, 8'd0, 8'd0, 8'h00}},
			'{CMD_KEY, KEY_BS, 8'd0, 1'b1, '{ACT_NONE, 8'h00, 8'd0, 8'd0, 8'h00}},
			'{CMD_KEY, KEY_CTRLW, 8'd0, 1'b1, '{ACT_NONE, 8'h00, 8'd0, 8'd0, 8'h00}},
			'{CMD_KEY, KEY_CTRLU, 8'd0, 1'b1, '{ACT_NONE, 8'h00, 8'd0, 8'd0, 8'h00}},
			'{CMD_KEY, KEY_DEL, 8'd0, 1'b1, '{ACT_NONE, 8'h00, 8'd0, 8'd0, 8'h00}},
			'{CMD_KEY, KEY_NUL, 8'd0, 1'b1, '{ACT_NONE, 8'h00, 8'd0, 8'd0, 8'h00}},
			'{CMD_KEY, 8'h61, 8'd0, 1'b1, '{ACT_ECHO, 8'h61, 8'd0, 8'd1, 8'h00}},
			'{CMD_KEY, 8'hFF, 8'd0, 1'b1, '{ACT_ECHO, 8'hFF, 8'd0, 8'd2, 8'h00}},
			'{CMD_KEY, KEY_SPACE, 8'd0, 1'b1, '{ACT_ECHO, KEY_SPACE, 8'd0, 8'd3, 8'h00}},
			'{CMD_KEY, 8'h62, 8'd0, 1'b1, '{ACT_ECHO, 8'h62, 8'd0, 8'd4, 8'h00}},
			'{CMD_KEY, KEY_TAB, 8'd0, 1'b1, '{ACT_TAB, 8'h00, 8'd0, 8'd8, 8'h00}},
			'{CMD_KEY, 8'h01, 8'd0, 1'b1, '{ACT_ECHO, 8'h01, 8'd0, 8'd9, 8'h00}},
			'{CMD_READ, 8'h00, 8'd0, 1'b1, '{ACT_READ, 8'h00, 8'd0, 8'd9, 8'h61}},
			'{CMD_READ, 8'h00, 8'd1, 1'b1, '{ACT_READ, 8'h00, 8'd0, 8'd9, 8'hFF}},
			'{CMD_READ, 8'h00, 8'd128, 1'b1, '{ACT_READ, 8'h00, 8'd0, 8'd9, 8'h00}},
			'{CMD_KEY, KEY_CTRLW, 8'd0, 1'b0, '0},
			'{CMD_KEY, KEY_BS, 8'd0, 1'b0, '0},
			'{CMD_KEY, KEY_CR, 8'd0, 1'b0, '0},
			'{CMD_READ, 8'h00, 8'd2, 1'b0, '0},
			'{CMD_KEY, 8'h63, 8'd0, 1'b1, '{ACT_ECHO, 8'h63, 8'd0, 8'd1, 8'h00}},
			'{CMD_KEY, KEY_CTRLU, 8'd0, 1'b1, '{ACT_ERASE, 8'h00, 8'd1, 8'd0, 8'h00}},
			'{CMD_KEY, 8'h80, 8'd0, 1'b0, '0},
			'{CMD_KEY, KEY_CTRLC, 8'd0, 1'b1, '{ACT_INTR, 8'h00, 8'd0, 8'd0, 8'h00}},
			'{CMD_KEY, KEY_LF, 8'd0, 1'b1, '{ACT_DONE, 8'h00, 8'd0, 8'd0, 8'h00}},
			'{CMD_KEY, KEY_DEL, 8'd0, 1'b1, '{ACT_NONE, 8'h00, 8'd0, 8'd0, 8'h00}}
		};

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < SCRIPT_LEN; i++)
			issue(script[i].cmd, script[i].key, script[i].idx, script[i].typed, script[i].want);
		drain();

		while (sent < ITEMS) begin
			gap_pct = ($urandom_range(2) == 0) ? 0 : 25;
			kind = $urandom_range(9);
			kind = (kind < 6) ? 0 : (kind < 7) ? 1 : 2;
			nkeys = (kind == 1) ? $urandom_range(150, 120) :
				(kind == 0) ? $urandom_range(25, 1) : $urandom_range(15, 3);
			for (int k = 0; k < nkeys; k++) begin
				if ($urandom_range(99) < 15)
					issue(CMD_READ, 8'($urandom), pick_index(), 1'b0, '0);
				else
					issue(CMD_KEY, pick_key(kind), 8'($urandom_range(128)), 1'b0, '0);
			end
			if (kind != 2)
				issue(CMD_KEY, $urandom_range(1) ? KEY_CR : KEY_LF,
					8'($urandom_range(128)), 1'b0, '0);
			if (sent < ITEMS - QUIET_TAIL && $urandom_range(9) == 0)
				drain();
		end

		drain();
		repeat (300) @(posedge clk);
		if (mismatches == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
